FILE: design/clb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and codes of the cursor list buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

   localparam logic [2:0] MODE_START   = 3'd0;
   localparam logic [2:0] MODE_ADVANCE = 3'd1;
   localparam logic [2:0] MODE_INSERT  = 3'd2;
   localparam logic [2:0] MODE_ATTACH  = 3'd3;
   localparam logic [2:0] MODE_REMOVE  = 3'd4;

   localparam logic [1:0] ST_DONE       = 2'd0;
   localparam logic [1:0] ST_NO_CURRENT = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        has_current;
      logic [31:0] current_value;
      logic [6:0]  count;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_en_type;

endpackage

FILE: design/cursor_list_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_buffer_top
// Ordered list with a cursor, held in one RAM, with an output register.
// ----------------------------------------------------------------------------
// Sequence: start, advance, unused codes and removes that move nothing go from
// accept to a readback of the current entry, then to the output register;
// inserts and attaches write the new entry before the readback. Moves come
// first: one entry per cycle through the RAM, then a drain. Throughput: one
// item at a time; req_stall holds until the result is loaded, which a response stall can delay.
// Reset: empty list, cursor at zero, no result pending; RAM contents undefined.
// ----------------------------------------------------------------------------
module cursor_list_buffer_top #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  clb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output clb_pkg::rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                  out_valid;
   logic                  out_free;
   clb_pkg::rsp_type      out_data;
   clb_pkg::mem_en_type   mem_en;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   clb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   clb_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_free  (out_free),
      .mem_en    (mem_en),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   clb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_en.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_en.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = out_valid;
         if (out_valid) begin
            rsp_data_in = out_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/clb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module clb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/clb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_seq
// Operation sequencer: cursor and count, entry shifting through the RAM,
// readback of the current entry.
// ----------------------------------------------------------------------------
module clb_seq #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  clb_pkg::req_type        req_data,
   output logic                    out_valid,
   output clb_pkg::rsp_type        out_data,
   input  logic                    out_free,
   output clb_pkg::mem_en_type     mem_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   output logic [DATA_WIDTH-1:0]   wr_data,
   input  logic [DATA_WIDTH-1:0]   rd_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_LOOK  = 3'd4;
   localparam logic [2:0] S_DATA  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         cursor_ff, cursor_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  wpend_ff, wpend_in;
   logic [1:0]            status_ff, status_in;
   logic [AW-1:0]         src_ff, src_in;
   logic [AW-1:0]         last_ff, last_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         wdst_ff, wdst_in;
   logic                  up_ff, up_in;
   logic                  put_ff, put_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;

   logic          has;
   logic          full;
   logic [CW-1:0] pos_c;

   assign has  = cursor_ff < count_ff;
   assign full = count_ff == CAP_CNT;

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      wpend_in     = 1'b0;
      status_in    = status_ff;
      src_in       = src_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      wdst_in      = wdst_ff;
      up_in        = up_ff;
      put_in       = put_ff;
      value_in     = value_ff;
      pos_c        = '0;
      mem_en.rd_en = 1'b0;
      mem_en.wr_en = wpend_ff || (state_ff == S_PUT);
      rd_addr      = src_ff;
      out_valid    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in  = DATA_WIDTH'(req_data.value);
               status_in = clb_pkg::ST_DONE;
               put_in    = 1'b0;
               up_in     = 1'b1;
               state_in  = S_LOOK;
               case (req_data.mode)
                  clb_pkg::MODE_START: begin
                     cursor_in = '0;
                  end
                  clb_pkg::MODE_ADVANCE: begin
                     if (has) begin
                        cursor_in = cursor_ff + ONE;
                     end else begin
                        status_in = clb_pkg::ST_NO_CURRENT;
                     end
                  end
                  clb_pkg::MODE_INSERT, clb_pkg::MODE_ATTACH: begin
                     if (full) begin
                        status_in = clb_pkg::ST_FULL;
                     end else begin
                        if (req_data.mode == clb_pkg::MODE_INSERT) begin
                           pos_c = has ? cursor_ff : '0;
                        end else begin
                           pos_c = has ? (cursor_ff + ONE) : count_ff;
                        end
                        cursor_in = pos_c;
                        count_in  = count_ff + ONE;
                        put_in    = 1'b1;
                        pos_in    = pos_c[AW-1:0];
                        src_in    = AW'(count_ff - ONE);
                        last_in   = pos_c[AW-1:0];
                        state_in  = (count_ff > pos_c) ? S_SHIFT : S_PUT;
                     end
                  end
                  clb_pkg::MODE_REMOVE: begin
                     if (has) begin
                        count_in = count_ff - ONE;
                        if ((cursor_ff + ONE) < count_ff) begin
                           src_in   = AW'(cursor_ff + ONE);
                           last_in  = AW'(count_ff - ONE);
                           up_in    = 1'b0;
                           state_in = S_SHIFT;
                        end
                     end else begin
                        status_in = clb_pkg::ST_NO_CURRENT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT: begin
            mem_en.rd_en = 1'b1;
            rd_addr      = src_ff;
            wpend_in     = 1'b1;
            wdst_in      = up_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
            if (src_ff == last_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = up_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
            end
         end
         S_DRAIN: begin
            state_in = put_ff ? S_PUT : S_LOOK;
         end
         S_PUT: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            mem_en.rd_en = has;
            rd_addr      = cursor_ff[AW-1:0];
            state_in     = S_DATA;
         end
         S_DATA: begin
            out_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall    = state_ff != S_IDLE;
   assign wr_addr      = (state_ff == S_PUT) ? pos_ff : wdst_ff;
   assign wr_data      = (state_ff == S_PUT) ? value_ff : rd_data;

   always_comb begin
      out_data.status        = status_ff;
      out_data.has_current   = has;
      out_data.current_value = has ? 32'(rd_data) : '0;
      out_data.count         = 7'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         count_ff  <= '0;
         wpend_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         wpend_ff  <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      src_ff    <= src_in;
      last_ff   <= last_in;
      pos_ff    <= pos_in;
      wdst_ff   <= wdst_in;
      up_ff     <= up_in;
      put_ff    <= put_in;
      value_ff  <= value_in;
   end

endmodule

FILE: design/clb_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_check
// Port-level checks of the cursor list buffer, bound to the top level.
// ----------------------------------------------------------------------------
module clb_check #(
   parameter int CAPACITY = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input clb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transfer changed");

   a_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_current |-> rsp_data.current_value == 32'd0)
      else $error("value without current entry");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == clb_pkg::ST_FULL |-> rsp_data.count == 7'(CAPACITY))
      else $error("full status below capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer accepted while busy");

   a_empty_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.count == 7'd0 && CAPACITY < 128 |-> !rsp_data.has_current)
      else $error("current entry in empty list");

endmodule

bind cursor_list_buffer_top clb_check #(.CAPACITY(CAPACITY)) u_clb_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: dv/clb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_checker
// Watches both channels of the cursor list buffer. Each request transfer
// updates a behavioral copy of the list, its count and its cursor, and queues
// the response it should produce; each response transfer is compared field
// by field with the oldest queued response.
// ----------------------------------------------------------------------------
module clb_checker #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  clb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  clb_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   logic [31:0]      list_entries [0:CAPACITY-1];
   int               list_len;
   int               cursor_pos;
   clb_pkg::rsp_type expected_rsp_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      list_len   = 0;
      cursor_pos = 0;
   end

   function automatic clb_pkg::rsp_type apply_list_op(clb_pkg::req_type item);
      clb_pkg::rsp_type result;
      logic [1:0]       status;
      int               k;
      status = clb_pkg::ST_DONE;
      case (item.mode)
         clb_pkg::MODE_START: begin
            cursor_pos = 0;
         end
         clb_pkg::MODE_ADVANCE: begin
            if (cursor_pos < list_len) cursor_pos++;
            else status = clb_pkg::ST_NO_CURRENT;
         end
         clb_pkg::MODE_INSERT: begin
            if (list_len >= CAPACITY) begin
               status = clb_pkg::ST_FULL;
            end else begin
               if (cursor_pos >= list_len) cursor_pos = 0;
               for (k = list_len; k > cursor_pos; k--) list_entries[k] = list_entries[k-1];
               list_entries[cursor_pos] = item.value;
               list_len++;
            end
         end
         clb_pkg::MODE_ATTACH: begin
            if (list_len >= CAPACITY) begin
               status = clb_pkg::ST_FULL;
            end else begin
               if (cursor_pos < list_len) begin
                  for (k = list_len; k > cursor_pos + 1; k--) list_entries[k] = list_entries[k-1];
                  cursor_pos++;
               end else begin
                  cursor_pos = list_len;
               end
               list_entries[cursor_pos] = item.value;
               list_len++;
            end
         end
         clb_pkg::MODE_REMOVE: begin
            if (cursor_pos < list_len) begin
               for (k = cursor_pos; k + 1 < list_len; k++) list_entries[k] = list_entries[k+1];
               list_len--;
            end else begin
               status = clb_pkg::ST_NO_CURRENT;
            end
         end
         default: begin
         end
      endcase
      result.status = status;
      if (cursor_pos < list_len) begin
         result.has_current   = 1'b1;
         result.current_value = list_entries[cursor_pos];
      end else begin
         result.has_current   = 1'b0;
         result.current_value = '0;
      end
      result.count = 7'(list_len);
      return result;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      clb_pkg::rsp_type want;
      if (reset) begin
         list_len   = 0;
         cursor_pos = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none expected, expected none actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("has_current", 32'(want.has_current),
                             32'(rsp_data.has_current));
               compare_field("current_value", want.current_value, rsp_data.current_value);
               compare_field("count", 32'(want.count), 32'(rsp_data.count));
            end
         end
         if (req_valid && !req_stall) expected_rsp_q.push_back(apply_list_op(req_data));
      end
      pending = expected_rsp_q.size();
   end

endmodule

FILE: dv/tb_cursor_list_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_list_buffer_top
// Drives the cursor list buffer with a directed run through every operation
// and its corner cases, then with phases of random operations that grow the
// list to full, wander and drain it, under random request gaps and response
// stalls. The checker beside the block scores every response.
// ----------------------------------------------------------------------------
module tb_cursor_list_buffer_top;

   localparam int CAPACITY      = 64;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 100;
   localparam int SEGMENT_LEN   = 150;
   localparam int QUIET_START   = 800;

   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;

   typedef enum int {PHASE_GROW, PHASE_WANDER, PHASE_SHRINK} phase_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   clb_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   clb_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               cycle_count;
   logic             quiet;

   cursor_list_buffer_top #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   clb_checker #(
      .CAPACITY (CAPACITY)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // response stall: random bursts, none once the quiet tail starts
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic push_op(logic [2:0] mode, logic [31:0] value);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data.mode <= mode;
      req_data.value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_mode(phase_type phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            if (roll < 40) return clb_pkg::MODE_INSERT;
            if (roll < 80) return clb_pkg::MODE_ATTACH;
            if (roll < 88) return clb_pkg::MODE_ADVANCE;
            if (roll < 94) return clb_pkg::MODE_START;
            if (roll < 98) return clb_pkg::MODE_REMOVE;
         end
         PHASE_SHRINK: begin
            if (roll < 15) return clb_pkg::MODE_START;
            if (roll < 25) return clb_pkg::MODE_ADVANCE;
            if (roll < 75) return clb_pkg::MODE_REMOVE;
            if (roll < 85) return clb_pkg::MODE_INSERT;
            if (roll < 95) return clb_pkg::MODE_ATTACH;
         end
         default: begin
            if (roll < 15) return clb_pkg::MODE_START;
            if (roll < 35) return clb_pkg::MODE_ADVANCE;
            if (roll < 55) return clb_pkg::MODE_INSERT;
            if (roll < 75) return clb_pkg::MODE_ATTACH;
            if (roll < 95) return clb_pkg::MODE_REMOVE;
         end
      endcase
      return 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
   endfunction

   initial begin
      phase_type phase_plan [6];
      int        n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      quiet     = 1'b0;
      phase_plan = '{PHASE_GROW, PHASE_WANDER, PHASE_SHRINK,
                     PHASE_GROW, PHASE_SHRINK, PHASE_WANDER};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: cursor ops, removal and unused codes
      push_op(clb_pkg::MODE_START, 32'h0);
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      push_op(clb_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
      for (logic [3:0] m = 4'(MODE_SPARE_A); m <= 4'(MODE_SPARE_C); m++)
         push_op(m[2:0], 32'hFFFF_FFFF);
      // insert at front of empty list, attach after current
      push_op(clb_pkg::MODE_INSERT, 32'h0000_0000);
      push_op(clb_pkg::MODE_ATTACH, 32'hFFFF_FFFF);
      // step off the end, then append with no current entry
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      push_op(clb_pkg::MODE_ATTACH, 32'h1234_5678);
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      // insert with no current entry goes to the front
      push_op(clb_pkg::MODE_INSERT, 32'h89AB_CDEF);
      push_op(clb_pkg::MODE_START, 32'h0);
      push_op(clb_pkg::MODE_INSERT, 32'h0F0F_0F0F);
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      push_op(clb_pkg::MODE_ATTACH, 32'hF0F0_F0F0);
      push_op(clb_pkg::MODE_REMOVE, 32'h0);
      push_op(clb_pkg::MODE_START, 32'h0);
      push_op(clb_pkg::MODE_REMOVE, 32'h0);
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      push_op(clb_pkg::MODE_ADVANCE, 32'h0);
      push_op(clb_pkg::MODE_REMOVE, 32'h0);
      push_op(clb_pkg::MODE_REMOVE, 32'h0);

      n = 0;
      foreach (phase_plan[p]) begin
         repeat (SEGMENT_LEN) begin
            if (n >= QUIET_START) quiet = 1'b1;
            push_op(pick_mode(phase_plan[p]), pick_value());
            n++;
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
